>>> rtl/umsb_pkg.sv
package umsb_pkg;

  // Commands carried by an input request.
  typedef enum logic [1:0] {
    CMD_PACKET    = 2'd0,
    CMD_TX_SLOT   = 2'd1,
    CMD_NOTES_OFF = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] len;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } op_t;

  // Bytes of the controller 120 message sent on every channel.
  localparam logic [7:0] CTRL_CHANGE_STATUS = 8'hB0;
  localparam logic [7:0] CTRL_ALL_SOUND_OFF = 8'h78;
  localparam logic [7:0] CTRL_VALUE_ZERO    = 8'h00;
  localparam int         NUM_CHANNELS       = 16;
  localparam int         CHAN_W             = $clog2(NUM_CHANNELS);

  // Position of a byte within the controller message.
  localparam logic [1:0] PHASE_STATUS = 2'd0;
  localparam logic [1:0] PHASE_CTRL   = 2'd1;
  localparam logic [1:0] PHASE_VALUE  = 2'd2;

  // Number of MIDI bytes that belong to a packet of the given code index.
  function automatic logic [1:0] packet_len(input logic [3:0] cin);
    logic [1:0] len;
    unique case (cin)
      4'h0, 4'h1:             len = 2'd0;
      4'h5, 4'hF:             len = 2'd1;
      4'h2, 4'h6, 4'hC, 4'hD: len = 2'd2;
      default:                len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/umsb_front.sv
module umsb_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [3:0]            code_index,
  input  logic [7:0]            midi_byte_first,
  input  logic [7:0]            midi_byte_second,
  input  logic [7:0]            midi_byte_third,
  input  logic                  queue_full,
  output logic                  push_valid,
  output umsb_pkg::op_t         push_op
);

  // The front end stalls only when the request queue has no room.
  assign in_stall   = queue_full;
  assign push_valid = in_valid && !queue_full;

  // Classify the request and look up the packet length.
  always_comb begin
    push_op.cmd   = umsb_pkg::cmd_t'(command);
    push_op.len   = (umsb_pkg::cmd_t'(command) == umsb_pkg::CMD_PACKET)
                    ? umsb_pkg::packet_len(code_index) : 2'd0;
    push_op.byte0 = midi_byte_first;
    push_op.byte1 = midi_byte_second;
    push_op.byte2 = midi_byte_third;
  end

endmodule

>>> rtl/umsb_opq.sv
module umsb_opq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  umsb_pkg::op_t push_op,
  output logic          full,
  output logic          pop_valid,
  output umsb_pkg::op_t pop_op,
  input  logic          pop
);

  umsb_pkg::op_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt == 2'd2);
  assign pop_valid = (cnt != 2'd0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Two-entry request queue between front and back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_op;
        wr_ptr          <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> rtl/umsb_exec.sv
module umsb_exec #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  umsb_pkg::op_t op,
  output logic          op_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          tx_valid,
  output logic [7:0]    tx_byte,
  output logic          accepted,
  output logic [6:0]    fill_level
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_READ  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t                      state;
  logic [7:0]                  mem [QUEUE_DEPTH];
  logic [7:0]                  rd_data;
  logic [AW-1:0]               wptr;
  logic [AW-1:0]               rptr;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_inc;
  logic [CW-1:0]               count_dec;
  logic                        fits;
  logic [1:0]                  rem;
  logic [7:0]                  pend0;
  logic [7:0]                  pend1;
  logic [7:0]                  pend2;
  logic [umsb_pkg::CHAN_W-1:0] chan;
  logic [1:0]                  phase;
  logic                        mem_we;
  logic [7:0]                  mem_wdata;

  function automatic logic [AW-1:0] ptr_step(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign fits      = ({1'b0, count} + (CW+1)'(op.len)) <= (CW+1)'(QUEUE_DEPTH);
  assign op_pop    = (state == S_IDLE) && op_valid && !out_valid;

  // Byte written to the FIFO this cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = pend0;
    if (state == S_PUSH) begin
      mem_we = 1'b1;
    end else if (state == S_CLEAR) begin
      mem_we = 1'b1;
      case (phase)
        umsb_pkg::PHASE_STATUS:
          mem_wdata = umsb_pkg::CTRL_CHANGE_STATUS | 8'(chan);
        umsb_pkg::PHASE_CTRL:
          mem_wdata = umsb_pkg::CTRL_ALL_SOUND_OFF;
        default:
          mem_wdata = umsb_pkg::CTRL_VALUE_ZERO;
      endcase
    end
  end

  // FIFO storage with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr] <= mem_wdata;
    end
    rd_data <= mem[rptr];
  end

  // Sequencer that carries out one request at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (op_pop) begin
            tx_valid   <= 1'b0;
            tx_byte    <= 8'd0;
            // Only a packet that does not fit is refused.
            accepted   <= (op.cmd != umsb_pkg::CMD_PACKET) || fits;
            fill_level <= count[6:0];
            unique case (op.cmd)
              umsb_pkg::CMD_PACKET: begin
                pend0 <= op.byte0;
                pend1 <= op.byte1;
                pend2 <= op.byte2;
                rem   <= op.len;
                if (!fits) begin
                  out_valid <= 1'b1;
                end else if (op.len == 2'd0) begin
                  out_valid <= 1'b1;
                end else begin
                  state <= S_PUSH;
                end
              end
              umsb_pkg::CMD_TX_SLOT: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  rptr  <= ptr_step(rptr);
                  count <= count_dec;
                  state <= S_READ;
                end
              end
              umsb_pkg::CMD_NOTES_OFF: begin
                wptr  <= '0;
                rptr  <= '0;
                count <= '0;
                chan  <= '0;
                phase <= umsb_pkg::PHASE_STATUS;
                state <= S_CLEAR;
              end
              umsb_pkg::CMD_NONE: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_PUSH: begin
          wptr  <= ptr_step(wptr);
          count <= count_inc;
          pend0 <= pend1;
          pend1 <= pend2;
          rem   <= rem - 2'd1;
          if (rem == 2'd1) begin
            fill_level <= count_inc[6:0];
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          tx_valid   <= 1'b1;
          tx_byte    <= rd_data;
          fill_level <= count[6:0];
          out_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_CLEAR: begin
          wptr  <= ptr_step(wptr);
          count <= count_inc;
          if (phase == umsb_pkg::PHASE_VALUE) begin
            phase <= umsb_pkg::PHASE_STATUS;
            chan  <= chan + umsb_pkg::CHAN_W'(1);
          end else begin
            phase <= phase + 2'd1;
          end
          if ((chan == umsb_pkg::CHAN_W'(umsb_pkg::NUM_CHANNELS - 1)) &&
              (phase == umsb_pkg::PHASE_VALUE)) begin
            fill_level <= count_inc[6:0];
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/usb_midi_to_serial_bridge_unit.sv
// The single FIFO write port takes one byte per cycle and the back end runs one request at a time.
// Reset (rst, synchronous) empties the FIFO and the request queue; the byte store itself
// is not cleared, as only written entries are ever read.
module usb_midi_to_serial_bridge_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [3:0] code_index,
  input  logic [7:0] midi_byte_first,
  input  logic [7:0] midi_byte_second,
  input  logic [7:0] midi_byte_third,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       accepted,
  output logic [6:0] fill_level
);

  logic          push_valid;
  umsb_pkg::op_t push_op;
  logic          queue_full;
  logic          op_valid;
  umsb_pkg::op_t op;
  logic          op_pop;

  // Front end: takes requests and classifies them.
  umsb_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .code_index       (code_index),
    .midi_byte_first  (midi_byte_first),
    .midi_byte_second (midi_byte_second),
    .midi_byte_third  (midi_byte_third),
    .queue_full       (queue_full),
    .push_valid       (push_valid),
    .push_op          (push_op)
  );

  // Short queue that decouples the two halves.
  umsb_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (queue_full),
    .pop_valid  (op_valid),
    .pop_op     (op),
    .pop        (op_pop)
  );

  // Back end: byte FIFO and its sequencer.
  umsb_exec #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op         (op),
    .op_pop     (op_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .accepted   (accepted),
    .fill_level (fill_level)
  );

endmodule

>>> dv/usb_midi_to_serial_bridge_unit_test.sv
module usb_midi_to_serial_bridge_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 64;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int CHUNK = 50;
  localparam int CYCLE_LIMIT = 900_000;
  localparam int SETTLE_CYCLES = 64;

  // Number of MIDI bytes carried by each code index.
  localparam logic [1:0] CIN_BYTES [16] = '{
    2'd0, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1
  };

  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic [6:0] fill_level;
  } tx_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = umsb_pkg::CMD_NONE;
  logic [3:0] code_index = '0;
  logic [7:0] midi_byte_first = '0;
  logic [7:0] midi_byte_second = '0;
  logic [7:0] midi_byte_third = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       accepted;
  logic [6:0] fill_level;

  // Predicted contents of the byte FIFO and the results still to arrive.
  logic [7:0] queued_bytes [$];
  tx_result_t expected_tx_results [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  usb_midi_to_serial_bridge_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .code_index(code_index),
    .midi_byte_first(midi_byte_first),
    .midi_byte_second(midi_byte_second),
    .midi_byte_third(midi_byte_third),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte),
    .accepted(accepted),
    .fill_level(fill_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the serial output of one request and updates the FIFO copy.
  function automatic void serialise_request(input umsb_pkg::cmd_t cmd, input logic [3:0] cin,
                                            input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
    tx_result_t r;
    logic [7:0] pkt [3];
    int n;
    r = '{tx_valid: 1'b0, tx_byte: 8'h00, accepted: 1'b1, fill_level: 7'd0};
    pkt = '{b0, b1, b2};
    n = CIN_BYTES[cin];
    case (cmd)
      umsb_pkg::CMD_PACKET: begin
        if (queued_bytes.size() + n > QUEUE_DEPTH) begin
          r.accepted = 1'b0;
        end else begin
          for (int i = 0; i < n; i++) queued_bytes.push_back(pkt[i]);
        end
      end
      umsb_pkg::CMD_TX_SLOT: begin
        if (queued_bytes.size() > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = queued_bytes.pop_front();
        end
      end
      umsb_pkg::CMD_NOTES_OFF: begin
        queued_bytes.delete();
        for (int ch = 0; ch < umsb_pkg::NUM_CHANNELS; ch++) begin
          if (queued_bytes.size() < QUEUE_DEPTH)
            queued_bytes.push_back(umsb_pkg::CTRL_CHANGE_STATUS | 8'(ch));
          if (queued_bytes.size() < QUEUE_DEPTH)
            queued_bytes.push_back(umsb_pkg::CTRL_ALL_SOUND_OFF);
          if (queued_bytes.size() < QUEUE_DEPTH)
            queued_bytes.push_back(umsb_pkg::CTRL_VALUE_ZERO);
        end
      end
      default: ;
    endcase
    r.fill_level = 7'(queued_bytes.size());
    expected_tx_results.push_back(r);
  endfunction

  // Presents one request, after a random gap if the sender idles, and waits until it is taken.
  task automatic send_request(input umsb_pkg::cmd_t cmd, input logic [3:0] cin,
                              input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
    int gap;
    gap = sender_idles ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    code_index <= cin;
    midi_byte_first <= b0;
    midi_byte_second <= b1;
    midi_byte_third <= b2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    serialise_request(cmd, cin, b0, b1, b2);
  endtask

  // Holds the sender back until every predicted result has been seen.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (expected_tx_results.size() != 0) @(posedge clk);
  endtask

  // Transmit on an empty FIFO and the unused command straight after reset.
  task automatic test_idle_commands;
    send_request(umsb_pkg::CMD_TX_SLOT, 4'h0, 8'h00, 8'h00, 8'h00);
    send_request(umsb_pkg::CMD_NONE, 4'hF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // One packet of each code index, with data at both extremes.
  task automatic test_code_indexes;
    logic [7:0] lo;
    for (int c = 0; c < 16; c++) begin
      lo = c[0] ? 8'hFF : 8'h00;
      send_request(umsb_pkg::CMD_PACKET, 4'(c), lo, ~lo, {4'(c), ~4'(c)});
    end
    wait_for_results();
  endtask

  // All notes off over a part-full FIFO, then filling it to the brim so that
  // packets which no longer fit are refused while smaller ones still go in.
  task automatic test_full_fifo;
    send_request(umsb_pkg::CMD_NOTES_OFF, 4'h3, 8'h90, 8'h40, 8'h7F);
    for (int i = 0; i < 5; i++)
      send_request(umsb_pkg::CMD_PACKET, 4'h3, 8'hFF, 8'h80, 8'(i));
    send_request(umsb_pkg::CMD_PACKET, 4'h4, 8'hF0, 8'h7E, 8'h01);
    send_request(umsb_pkg::CMD_PACKET, 4'hF, 8'hF8, 8'h00, 8'h00);
    send_request(umsb_pkg::CMD_PACKET, 4'h0, 8'h12, 8'h34, 8'h56);
    send_request(umsb_pkg::CMD_PACKET, 4'h5, 8'hF6, 8'h00, 8'h00);
    send_request(umsb_pkg::CMD_TX_SLOT, 4'h0, 8'h00, 8'h00, 8'h00);
  endtask

  // Random traffic in chunks, each with its own mix of packets and transmit
  // slots so that the FIFO both fills up and runs dry, and its own idling.
  task automatic test_random_traffic;
    int pkt_pct;
    int roll;
    umsb_pkg::cmd_t cmd;
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % CHUNK == 0) begin
        case ($urandom_range(0, 3))
          0: pkt_pct = 25;
          1: pkt_pct = 45;
          2: pkt_pct = 55;
          default: pkt_pct = 75;
        endcase
        sender_idles = $urandom_range(0, 1);
        receiver_idles = $urandom_range(0, 1);
        if (k % (CHUNK * 8) == CHUNK * 4) wait_for_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = umsb_pkg::CMD_NOTES_OFF;
      else if (roll < 4) cmd = umsb_pkg::CMD_NONE;
      else if (roll < 4 + pkt_pct) cmd = umsb_pkg::CMD_PACKET;
      else cmd = umsb_pkg::CMD_TX_SLOT;
      send_request(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;
  endtask

  // Compares one result field and reports a mismatch.
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Every result taken is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    tx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tx_results.size() == 0) begin
        $display("%0t: result with none expected, actual tx_valid %0b tx_byte 0x%0h",
                 $time, tx_valid, tx_byte);
        fail_count++;
      end else begin
        want = expected_tx_results.pop_front();
        check_field("tx_valid", want.tx_valid, tx_valid);
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("accepted", want.accepted, accepted);
        check_field("fill_level", want.fill_level, fill_level);
      end
    end
  end

  // After each result the receiver may hold off for a random number of cycles.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (!rst && out_valid && !out_stall && receiver_idles) begin
      stall_left = $urandom_range(0, 17);
      if (stall_left > 0) out_stall <= 1'b1;
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("usb_midi_to_serial_bridge_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_code_indexes();
    test_full_fifo();
    test_random_traffic();
    while (expected_tx_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("usb_midi_to_serial_bridge_unit_test OK");
    end else begin
      $display("usb_midi_to_serial_bridge_unit_test NOT OK");
    end
    $finish;
  end

endmodule
